/* design/toc_pkg.sv */
package toc_pkg;

    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 13;
    localparam int DATA_W      = 8;
    localparam int PX_W        = 10;
    localparam int PY_W        = 9;
    localparam int PIXEL_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int CELL_W      = 12;
    localparam int BITPOS_W    = 3;
    localparam int ATTR_W      = 8;

    localparam int TEXT_ROWS_DEF   = 30;
    localparam int MAX_COLUMNS_DEF = 80;
    localparam int FONT_CHARS_DEF  = 256;

    localparam logic [COL_W-1:0] COLS_WIDE   = 7'd80;
    localparam logic [COL_W-1:0] COLS_NARROW = 7'd40;

    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FONT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPOSE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_EIGHTY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIX    = 2'd1;

    localparam logic [PIXEL_W-1:0] BLACK565 = 16'h0000;
    localparam logic [PIXEL_W-1:0] GREY565  = 16'h8410;

    typedef struct packed {
        logic                in_area;
        logic [CELL_W-1:0]   index;
        logic [BITPOS_W-1:0] bitpos;
        logic [2:0]          fontrow;
    } cell_t;

    function automatic logic [PIXEL_W-1:0] fg_color(input logic [3:0] idx);
        logic [PIXEL_W-1:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'h8000;
            4'd2:    c = 16'h0400;
            4'd3:    c = 16'h0010;
            4'd4:    c = 16'h8400;
            4'd5:    c = 16'h0410;
            4'd6:    c = 16'h8010;
            4'd7:    c = 16'h4208;
            4'd8:    c = 16'h8410;
            4'd9:    c = 16'hF800;
            4'd10:   c = 16'h07E0;
            4'd11:   c = 16'h001F;
            4'd12:   c = 16'hFFE0;
            4'd13:   c = 16'h07FF;
            4'd14:   c = 16'hF81F;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [PIXEL_W-1:0] bg_color(input logic [3:0] idx);
        logic [PIXEL_W-1:0] c;
        case (idx)
            4'd7:    c = 16'h2104;
            default: c = fg_color(idx);
        endcase
        return c;
    endfunction

    function automatic logic [PIXEL_W-1:0] halve565(input logic [PIXEL_W-1:0] p);
        return {1'b0, p[15:12], 1'b0, p[10:6], 1'b0, p[4:1]};
    endfunction

endpackage

/* design/toc_in_if.sv */
interface toc_in_if;
    logic                        valid;
    logic                        ready;
    logic [toc_pkg::CMD_W-1:0]   command;
    logic [toc_pkg::ADDR_W-1:0]  address;
    logic [toc_pkg::DATA_W-1:0]  write_data;
    logic [toc_pkg::PX_W-1:0]    pixel_x;
    logic [toc_pkg::PY_W-1:0]    pixel_y;
    logic [toc_pkg::PIXEL_W-1:0] gfx_pixel;

    modport source (
        output valid, command, address, write_data, pixel_x, pixel_y, gfx_pixel,
        input  ready
    );
    modport sink (
        input  valid, command, address, write_data, pixel_x, pixel_y, gfx_pixel,
        output ready
    );
endinterface

/* design/toc_out_if.sv */
interface toc_out_if;
    logic                        valid;
    logic                        ready;
    logic [toc_pkg::PIXEL_W-1:0] out_pixel;

    modport source (
        output valid, out_pixel,
        input  ready
    );
    modport sink (
        input  valid, out_pixel,
        output ready
    );
endinterface

/* design/toc_cfg_if.sv */
interface toc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [toc_pkg::CFG_INDEX_W-1:0] index;
    logic [toc_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/toc_ram.sv */
module toc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_mask,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read at the same edge as a write returns the old word
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIDTH; i++)
        begin
            if (wr_en && wr_mask[i])
            begin
                mem[wr_addr][i] <= wr_data[i];
            end
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/toc_cell_map.sv */
module toc_cell_map #(
    parameter int TEXT_ROWS   = toc_pkg::TEXT_ROWS_DEF,
    parameter int MAX_COLUMNS = toc_pkg::MAX_COLUMNS_DEF
) (
    input  logic                     eighty,
    input  logic [toc_pkg::PX_W-1:0] pixel_x,
    input  logic [toc_pkg::PY_W-1:0] pixel_y,
    output toc_pkg::cell_t           loc
);

    localparam int TEXT_WORDS = TEXT_ROWS * MAX_COLUMNS;

    logic [toc_pkg::COL_W-1:0]  col;
    logic [toc_pkg::COL_W-1:0]  width;
    logic [toc_pkg::ROW_W-1:0]  row;
    logic [toc_pkg::CELL_W-1:0] index;

    always_comb
    begin
        if (eighty)
        begin
            col        = pixel_x[9:3];
            loc.bitpos = pixel_x[2:0];
            width      = toc_pkg::COLS_WIDE;
        end
        else
        begin
            col        = {1'b0, pixel_x[9:4]};
            loc.bitpos = pixel_x[3:1];
            width      = toc_pkg::COLS_NARROW;
        end
        row         = pixel_y[8:4];
        loc.fontrow = pixel_y[3:1];
        index       = toc_pkg::CELL_W'(col)
                    + toc_pkg::CELL_W'(row) * toc_pkg::CELL_W'(width);
        loc.index   = index;
        loc.in_area = (col < width) && (32'(row) < TEXT_ROWS) && (32'(index) < TEXT_WORDS);
    end

endmodule

/* design/toc_shade.sv */
module toc_shade (
    input  logic                            mix,
    input  logic                            in_area,
    input  logic [toc_pkg::DATA_W-1:0]      font_bits,
    input  logic [toc_pkg::BITPOS_W-1:0]    bitpos,
    input  logic [toc_pkg::ATTR_W-1:0]      attr,
    input  logic [toc_pkg::PIXEL_W-1:0]     gfx,
    output logic [toc_pkg::PIXEL_W-1:0]     pixel
);

    logic                        lit;
    logic [toc_pkg::PIXEL_W-1:0] fg;
    logic [toc_pkg::PIXEL_W-1:0] bg;

    always_comb
    begin
        lit = font_bits[3'd7 - bitpos];
        fg  = toc_pkg::fg_color(attr[3:0]);
        bg  = toc_pkg::bg_color(attr[7:4]);
        if (!in_area)
        begin
            pixel = gfx;
        end
        else if (lit)
        begin
            pixel = fg;
        end
        else if (!mix)
        begin
            pixel = bg;
        end
        else if (bg == toc_pkg::BLACK565)
        begin
            pixel = gfx;
        end
        else if (bg == toc_pkg::GREY565)
        begin
            pixel = toc_pkg::halve565(gfx);
        end
        else
        begin
            pixel = bg;
        end
    end

endmodule

/* design/text_overlay_compositor.sv */
// flow: a compose transfer passes the s1, s2 and output registers in turn
// throughput: one item per cycle while the output is not stalled, set by the
//   text ram read, the font ram read and the output register forming a
//   three-stage pipeline that stalls as one
// write commands produce no result
// reset: eighty_columns clears, mix_with_graphics sets, pipeline empties;
//   text and font memories keep no reset value and hold garbage until written
module text_overlay_compositor #(
    parameter int TEXT_ROWS   = toc_pkg::TEXT_ROWS_DEF,
    parameter int MAX_COLUMNS = toc_pkg::MAX_COLUMNS_DEF,
    parameter int FONT_CHARS  = toc_pkg::FONT_CHARS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    toc_cfg_if.sink   cfg,
    toc_in_if.sink    pix_in,
    toc_out_if.source pix_out
);

    localparam int TEXT_WORDS = TEXT_ROWS * MAX_COLUMNS;
    localparam int TEXT_BYTES = TEXT_WORDS * 2;
    localparam int TEXT_AW    = $clog2(TEXT_WORDS);
    localparam int FONT_DEPTH = FONT_CHARS * 8;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int TEXT_W     = 2 * toc_pkg::DATA_W;

    logic eighty_reg;
    logic mix_reg;

    logic advance;
    logic accept;

    toc_pkg::cell_t cell_loc;

    logic                            s1_valid_reg;
    logic                            s1_inside_reg;
    logic [toc_pkg::BITPOS_W-1:0]    s1_bitpos_reg;
    logic [2:0]                      s1_fontrow_reg;
    logic [toc_pkg::PIXEL_W-1:0]     s1_gfx_reg;

    logic                            s2_valid_reg;
    logic                            s2_inside_reg;
    logic [toc_pkg::BITPOS_W-1:0]    s2_bitpos_reg;
    logic [toc_pkg::ATTR_W-1:0]      s2_attr_reg;
    logic [toc_pkg::PIXEL_W-1:0]     s2_gfx_reg;

    logic                            out_valid_reg;
    logic [toc_pkg::PIXEL_W-1:0]     out_pixel_reg;
    logic [toc_pkg::PIXEL_W-1:0]     out_pixel_next;

    logic                            text_wr_en;
    logic [TEXT_W-1:0]               text_wr_mask;
    logic [TEXT_W-1:0]               text_rd_data;
    logic                            font_wr_en;
    logic [FONT_AW-1:0]              font_rd_addr;
    logic [toc_pkg::DATA_W-1:0]      font_rd_data;
    logic [toc_pkg::DATA_W:0]        char_code;

    assign advance      = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = advance;
    assign accept       = pix_in.valid && advance;
    assign cfg.ready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eighty_reg <= 1'b0;
            mix_reg    <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                toc_pkg::CFG_EIGHTY: eighty_reg <= cfg.data[0];
                toc_pkg::CFG_MIX:    mix_reg    <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    toc_cell_map #(
        .TEXT_ROWS   (TEXT_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_cell_map (
        .eighty  (eighty_reg),
        .pixel_x (pix_in.pixel_x),
        .pixel_y (pix_in.pixel_y),
        .loc     (cell_loc)
    );

    // text memory: one word per cell, character low byte, attribute high byte
    assign text_wr_en   = accept && (pix_in.command == toc_pkg::CMD_TEXT)
                        && (32'(pix_in.address) < TEXT_BYTES);
    assign text_wr_mask = pix_in.address[0] ? {{toc_pkg::DATA_W{1'b1}}, {toc_pkg::DATA_W{1'b0}}}
                                            : {{toc_pkg::DATA_W{1'b0}}, {toc_pkg::DATA_W{1'b1}}};

    toc_ram #(
        .WIDTH (TEXT_W),
        .DEPTH (TEXT_WORDS)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (text_wr_en),
        .wr_addr (TEXT_AW'(pix_in.address[toc_pkg::ADDR_W-1:1])),
        .wr_mask (text_wr_mask),
        .wr_data ({pix_in.write_data, pix_in.write_data}),
        .rd_en   (advance),
        .rd_addr (cell_loc.index[TEXT_AW-1:0]),
        .rd_data (text_rd_data)
    );

    // character codes past the font wrap around
    always_comb
    begin
        char_code = {1'b0, text_rd_data[toc_pkg::DATA_W-1:0]};
        if (32'(char_code) >= FONT_CHARS)
        begin
            char_code = char_code - (toc_pkg::DATA_W + 1)'(FONT_CHARS);
        end
        font_rd_addr = FONT_AW'({char_code, s1_fontrow_reg});
    end

    assign font_wr_en = accept && (pix_in.command == toc_pkg::CMD_FONT)
                      && (32'(pix_in.address) < FONT_DEPTH);

    toc_ram #(
        .WIDTH (toc_pkg::DATA_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (font_wr_en),
        .wr_addr (FONT_AW'(pix_in.address)),
        .wr_mask ({toc_pkg::DATA_W{1'b1}}),
        .wr_data (pix_in.write_data),
        .rd_en   (advance),
        .rd_addr (font_rd_addr),
        .rd_data (font_rd_data)
    );

    toc_shade u_shade (
        .mix       (mix_reg),
        .in_area   (s2_inside_reg),
        .font_bits (font_rd_data),
        .bitpos    (s2_bitpos_reg),
        .attr      (s2_attr_reg),
        .gfx       (s2_gfx_reg),
        .pixel     (out_pixel_next)
    );

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept && (pix_in.command == toc_pkg::CMD_COMPOSE);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_inside_reg  <= cell_loc.in_area;
            s1_bitpos_reg  <= cell_loc.bitpos;
            s1_fontrow_reg <= cell_loc.fontrow;
            s1_gfx_reg     <= pix_in.gfx_pixel;
            s2_inside_reg  <= s1_inside_reg;
            s2_bitpos_reg  <= s1_bitpos_reg;
            s2_attr_reg    <= text_rd_data[TEXT_W-1:toc_pkg::DATA_W];
            s2_gfx_reg     <= s1_gfx_reg;
            out_pixel_reg  <= out_pixel_next;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;

    a_ready_only_blocked_by_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (pix_out.valid && !pix_out.ready)
    ) else $error("input stalled while output free");

    a_compose_enters_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready && pix_in.command == toc_pkg::CMD_COMPOSE)
            |=> s1_valid_reg
    ) else $error("accepted compose lost at first stage");

    a_outside_passes_gfx: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg && !s2_inside_reg)
            |=> (pix_out.out_pixel == $past(s2_gfx_reg))
    ) else $error("pixel outside text area not passed through");

endmodule

/* sim/text_overlay_compositor_tb.sv */
`timescale 1ns / 1ps

module text_overlay_compositor_tb;
    import toc_pkg::*;

    localparam int TEXT_BYTES     = TEXT_ROWS_DEF * MAX_COLUMNS_DEF * 2;
    localparam int FONT_BYTES     = FONT_CHARS_DEF * 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_PAD      = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        logic [PX_W-1:0]    pixel_x;
        logic [PY_W-1:0]    pixel_y;
        logic [PIXEL_W-1:0] gfx_pixel;
    } overlay_item_t;

    class overlay_scoreboard;
        logic [DATA_W-1:0]  text_bytes [TEXT_BYTES];
        bit                 text_known [TEXT_BYTES];
        logic [DATA_W-1:0]  font_bytes [FONT_BYTES];
        bit                 font_known [FONT_BYTES];
        logic [PIXEL_W-1:0] fg_colors [16];
        logic [PIXEL_W-1:0] bg_colors [16];
        logic [PIXEL_W-1:0] pending_pixels [$];
        bit                 eighty;
        bit                 mix;
        int                 mismatches;

        function new();
            fg_colors = '{16'h0000, 16'h8000, 16'h0400, 16'h0010,
                          16'h8400, 16'h0410, 16'h8010, 16'h4208,
                          16'h8410, 16'hF800, 16'h07E0, 16'h001F,
                          16'hFFE0, 16'h07FF, 16'hF81F, 16'hFFFF};
            bg_colors = fg_colors;
            bg_colors[7] = 16'h2104;
            eighty = 1'b0;
            mix = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic value);
            if (idx == CFG_EIGHTY)
                eighty = value;
            else if (idx == CFG_MIX)
                mix = value;
        endfunction

        function bit find_cell(input int px, input int py, output int cell_addr,
                               output int bitpos, output int fontrow);
            int width;
            int col;
            int row;
            width = eighty ? 80 : 40;
            if (eighty)
            begin
                col = px >> 3;
                bitpos = px & 7;
            end
            else
            begin
                col = px >> 4;
                bitpos = (px & 15) >> 1;
            end
            row = py >> 4;
            fontrow = (py & 15) >> 1;
            cell_addr = 2 * (col + row * width);
            return col < width && row < TEXT_ROWS_DEF && cell_addr + 1 < TEXT_BYTES;
        endfunction

        // true when the pixel reads only memory bytes that were written
        function bit can_compose(input int px, input int py);
            int cell_addr;
            int bitpos;
            int fontrow;
            int ch;
            if (!find_cell(px, py, cell_addr, bitpos, fontrow))
                return 1'b1;
            if (!text_known[cell_addr] || !text_known[cell_addr + 1])
                return 1'b0;
            ch = int'(text_bytes[cell_addr]) % FONT_CHARS_DEF;
            return font_known[ch * 8 + fontrow];
        endfunction

        function logic [PIXEL_W-1:0] composed_pixel(input int px, input int py,
                                                     input logic [PIXEL_W-1:0] gfx);
            int cell_addr;
            int bitpos;
            int fontrow;
            int ch;
            logic [DATA_W-1:0]  attr;
            logic [DATA_W-1:0]  bits;
            logic [PIXEL_W-1:0] fg;
            logic [PIXEL_W-1:0] bg;
            logic [4:0]         red;
            logic [5:0]         green;
            logic [4:0]         blue;
            if (!find_cell(px, py, cell_addr, bitpos, fontrow))
                return gfx;
            ch = int'(text_bytes[cell_addr]) % FONT_CHARS_DEF;
            attr = text_bytes[cell_addr + 1];
            bits = font_bytes[ch * 8 + fontrow];
            fg = fg_colors[attr[3:0]];
            bg = bg_colors[attr[7:4]];
            if (bits[7 - bitpos])
                return fg;
            if (!mix)
                return bg;
            if (bg == BLACK565)
                return gfx;
            if (bg == GREY565)
            begin
                red = gfx[15:11] >> 1;
                green = gfx[10:5] >> 1;
                blue = gfx[4:0] >> 1;
                return {red, green, blue};
            end
            return bg;
        endfunction

        function void note_transfer(input overlay_item_t it);
            int addr;
            addr = int'(it.address);
            case (it.command)
                CMD_TEXT:
                    if (addr < TEXT_BYTES)
                    begin
                        text_bytes[addr] = it.write_data;
                        text_known[addr] = 1'b1;
                    end
                CMD_FONT:
                    if (addr < FONT_BYTES)
                    begin
                        font_bytes[addr] = it.write_data;
                        font_known[addr] = 1'b1;
                    end
                CMD_COMPOSE:
                    pending_pixels.push_back(composed_pixel(int'(it.pixel_x),
                                                            int'(it.pixel_y), it.gfx_pixel));
                default:
                    ;
            endcase
        endfunction

        function void check_pixel(input logic [PIXEL_W-1:0] actual);
            logic [PIXEL_W-1:0] want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel transfer: actual %h", actual);
                return;
            end
            want = pending_pixels.pop_front();
            if (want !== actual)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("pixel mismatch: expected %h actual %h", want, actual);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    bit   rx_hold = 1'b0;
    int   stuck_cycles = 0;

    overlay_scoreboard board = new();

    toc_cfg_if cfg_bus();
    toc_in_if  in_bus();
    toc_out_if out_bus();

    text_overlay_compositor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pix_in  (in_bus),
        .pix_out (out_bus)
    );

    always #5 clk = ~clk;

    function automatic overlay_item_t random_fields();
        overlay_item_t it;
        logic [31:0]   r;
        r = $urandom;
        it.command = r[CMD_W-1:0];
        it.write_data = r[15:8];
        r = $urandom;
        it.address = r[ADDR_W-1:0];
        it.pixel_x = r[31:22];
        it.pixel_y = r[21:13];
        r = $urandom;
        it.gfx_pixel = r[PIXEL_W-1:0];
        return it;
    endfunction

    task automatic send_item(input overlay_item_t it);
        while (!quiet && $urandom_range(99) < 28)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.command <= it.command;
        in_bus.address <= it.address;
        in_bus.write_data <= it.write_data;
        in_bus.pixel_x <= it.pixel_x;
        in_bus.pixel_y <= it.pixel_y;
        in_bus.gfx_pixel <= it.gfx_pixel;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        board.note_transfer(it);
    endtask

    task automatic send_write(input logic [CMD_W-1:0] cmd, input int addr,
                              input logic [DATA_W-1:0] data);
        overlay_item_t it;
        it = random_fields();
        it.command = cmd;
        it.address = addr[ADDR_W-1:0];
        it.write_data = data;
        send_item(it);
    endtask

    task automatic send_pixel(input int px, input int py, input logic [PIXEL_W-1:0] gfx);
        overlay_item_t it;
        it = random_fields();
        it.command = CMD_COMPOSE;
        it.pixel_x = px[PX_W-1:0];
        it.pixel_y = py[PY_W-1:0];
        it.gfx_pixel = gfx;
        send_item(it);
    endtask

    task automatic write_settings(input logic eighty, input logic mix);
        logic [CFG_INDEX_W-1:0] idx;
        logic                   value;
        int                     first;
        first = $urandom_range(1);
        for (int i = 0; i < 2; i++)
        begin
            idx = ((i ^ first) != 0) ? CFG_MIX : CFG_EIGHTY;
            value = (idx == CFG_EIGHTY) ? eighty : mix;
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data <= value;
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            board.set_reg(idx, value);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic directed_items();
        overlay_item_t it;
        // grey background halves graphics, doubled font bits in 40 columns
        send_write(CMD_TEXT, 0, 8'hFF);
        send_write(CMD_TEXT, 1, 8'h8F);
        send_write(CMD_FONT, 255 * 8, 8'hA5);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(2, 1, 16'hFFFF);
        send_pixel(3, 0, 16'h0000);
        // last cell of the 40 column screen, black background
        send_write(CMD_TEXT, 2398, 8'h00);
        send_write(CMD_TEXT, 2399, 8'h0F);
        send_write(CMD_FONT, 7, 8'h01);
        send_pixel(639, 479, 16'h0001);
        send_pixel(624, 479, 16'hFFFF);
        // colored background replaces graphics
        send_write(CMD_TEXT, 2, 8'h80);
        send_write(CMD_TEXT, 3, 8'h9C);
        send_write(CMD_FONT, 8'h80 * 8 + 3, 8'h00);
        send_pixel(16, 6, 16'h1234);
        // outside the text area
        send_pixel(1023, 511, 16'hFFFF);
        send_pixel(640, 0, 16'hA5A5);
        send_pixel(0, 480, 16'h5A5A);
        // writes past the end of memory, at its last bytes, and an unused command
        send_write(CMD_TEXT, 8191, 8'hFF);
        send_write(CMD_FONT, 2048, 8'hFF);
        send_write(CMD_FONT, FONT_BYTES - 1, 8'hFF);
        it = '1;
        it.command = CMD_NONE;
        send_item(it);
        send_write(CMD_TEXT, TEXT_BYTES - 1, 8'h7E);
        send_write(CMD_TEXT, TEXT_BYTES - 2, 8'h00);
    endtask

    // fill one text cell and some of its font rows, then compose inside it
    task automatic cell_burst(output int count);
        int                 width;
        int                 cw;
        int                 col;
        int                 row;
        int                 cell_addr;
        int                 ch;
        int                 k;
        int                 px;
        int                 py;
        int                 nrows;
        int                 npix;
        int                 rows_done [$];
        logic [DATA_W-1:0]  attr;
        logic [DATA_W-1:0]  bits;
        logic [31:0]        r;
        width = board.eighty ? 80 : 40;
        cw = board.eighty ? 8 : 16;
        col = $urandom_range(width - 1);
        row = $urandom_range(TEXT_ROWS_DEF - 1);
        cell_addr = 2 * (col + row * width);
        r = $urandom;
        ch = int'(r[7:0]);
        attr = r[15:8];
        case ($urandom_range(3))
            0: attr[7:4] = 4'd0;
            1: attr[7:4] = 4'd8;
            default: ;
        endcase
        send_write(CMD_TEXT, cell_addr, ch[7:0]);
        send_write(CMD_TEXT, cell_addr + 1, attr);
        nrows = $urandom_range(1, 8);
        for (int i = 0; i < nrows; i++)
        begin
            k = $urandom_range(7);
            r = $urandom;
            bits = r[7:0];
            if (r[9:8] == 2'd0)
                bits = r[10] ? 8'hFF : 8'h00;
            send_write(CMD_FONT, ch * 8 + k, bits);
            rows_done.push_back(k);
        end
        npix = $urandom_range(2, 6);
        for (int i = 0; i < npix; i++)
        begin
            k = rows_done[$urandom_range(rows_done.size() - 1)];
            px = col * cw + $urandom_range(cw - 1);
            py = row * 16 + k * 2 + $urandom_range(1);
            r = $urandom;
            if (board.can_compose(px, py))
                send_pixel(px, py, r[PIXEL_W-1:0]);
        end
        count = 2 + nrows + npix;
    endtask

    task automatic random_pixel();
        int          px;
        int          py;
        logic [31:0] r;
        r = $urandom;
        for (int i = 0; i < 10; i++)
        begin
            px = ($urandom_range(99) < 88) ? $urandom_range(639) : $urandom_range(640, 1023);
            py = ($urandom_range(99) < 88) ? $urandom_range(479) : $urandom_range(480, 511);
            if (board.can_compose(px, py))
            begin
                send_pixel(px, py, r[PIXEL_W-1:0]);
                return;
            end
        end
        send_pixel($urandom_range(640, 1023), $urandom_range(511), r[PIXEL_W-1:0]);
    endtask

    task automatic random_write();
        logic [CMD_W-1:0] cmd;
        int               addr;
        logic [31:0]      r;
        r = $urandom;
        cmd = r[0] ? CMD_FONT : CMD_TEXT;
        if (r[4:1] == 4'd0)
            addr = $urandom_range(8191);
        else
            addr = $urandom_range((cmd == CMD_TEXT) ? TEXT_BYTES - 1 : FONT_BYTES - 1);
        send_write(cmd, addr, r[15:8]);
    endtask

    task automatic random_phase(input int count);
        int            sent;
        int            n;
        int            pick;
        overlay_item_t it;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                cell_burst(n);
                sent += n;
            end
            else if (pick < 80)
            begin
                random_pixel();
                sent++;
            end
            else if (pick < 94)
            begin
                random_write();
                sent++;
            end
            else
            begin
                it = random_fields();
                it.command = CMD_NONE;
                send_item(it);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            board.check_pixel(out_bus.out_pixel);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("text_overlay_compositor_tb failed");
                $finish;
            end
        end
    end

    // output side: random back pressure, none while quiet, one long hold-off on request
    initial
    begin
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
                out_bus.ready <= 1'b1;
            end
            else if (quiet)
                out_bus.ready <= 1'b1;
            else
                out_bus.ready <= ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.command <= CMD_TEXT;
        in_bus.address <= '0;
        in_bus.write_data <= '0;
        in_bus.pixel_x <= '0;
        in_bus.pixel_y <= '0;
        in_bus.gfx_pixel <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_EIGHTY;
        cfg_bus.data <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        random_phase(200);
        wait_drained();

        write_settings(1'b1, 1'b1);
        random_phase(220);
        wait_drained();

        write_settings(1'b1, 1'b0);
        rx_hold = 1'b1;
        random_phase(230);
        wait_drained();

        write_settings(1'b0, 1'b0);
        quiet = 1'b1;
        random_phase(230);
        quiet = 1'b0;
        wait_drained();

        write_settings(1'b0, 1'b1);
        random_phase(230);
        wait_drained();

        write_settings(1'b1, 1'b1);
        random_phase(230);
        wait_drained();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("text_overlay_compositor_tb passed");
        else
            $display("text_overlay_compositor_tb failed");
        $finish;
    end
endmodule
